[src/lsp_pkg.sv]
// Shared types and constants for the shape packet parser.
// No dependencies; compiled first.
package lsp_pkg;

    localparam logic [7:0]  START_BYTE  = 8'hFF;
    localparam int unsigned FIELD_COUNT = 6;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 3;
    localparam int unsigned IDX_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_MODE   = 1'b1;

    localparam logic CHECK_XOR = 1'b0;
    localparam logic CHECK_SUM = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_COLLECT = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0] shape_type;
        logic [7:0] center_x;
        logic [7:0] center_y;
        logic [7:0] circle_radius;
        logic [7:0] point_x;
        logic [7:0] point_y;
    } shape_pkt_t;

    function automatic logic [7:0] fold_check(input logic mode, input logic [7:0] acc,
                                              input logic [7:0] b);
        logic [7:0] res;
        res = (mode == CHECK_SUM) ? (acc + b) : (acc ^ b);
        return res;
    endfunction

endpackage

[src/lsp_if.sv]
// Channel interfaces for the shape packet parser: byte input and packet output.
// No dependencies.
interface lsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsp_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] shape_type;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic [7:0] circle_radius;
    logic [7:0] point_x;
    logic [7:0] point_y;

    modport source (output valid, output shape_type, output center_x, output center_y,
                     output circle_radius, output point_x, output point_y, input ready);
    modport sink   (input valid, input shape_type, input center_x, input center_y,
                     input circle_radius, input point_x, input point_y, output ready);
endinterface

[src/lsp_parser.sv]
// Front end: frame parser with length check, field capture and running check.
// Depends on lsp_pkg.
module lsp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  lsp_pkg::cfg_wr_t    cfg,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    output logic                push,
    output lsp_pkg::shape_pkt_t pkt
);
    import lsp_pkg::*;

    localparam logic [IDX_W-1:0] FIELD_END  = IDX_W'(FIELD_COUNT);
    localparam logic [IDX_W-1:0] LAST_FIELD = IDX_W'(FIELD_COUNT - 1);

    logic [2:0]       limit_reg;
    logic             mode_reg;
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] len_reg, len_next;
    logic [7:0]       check_reg, check_next;
    logic [7:0]       held_reg [FIELD_COUNT];
    logic             store;
    logic             too_long;
    logic             in_range;

    assign too_long = in_byte > {5'b0, limit_reg};
    assign in_range = idx_reg < len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 3'd6;
            mode_reg  <= CHECK_XOR;
        end
        else if (cfg.en)
        begin
            unique case (cfg.index)
                CFG_LENGTH_LIMIT: limit_reg <= cfg.data;
                CFG_CHECK_MODE:   mode_reg  <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:    if (in_byte == START_BYTE) phase_next = PH_LENGTH;
            PH_LENGTH:  phase_next = too_long ? PH_HUNT : PH_COLLECT;
            PH_COLLECT:
            begin
                if (!in_range)
                    phase_next = PH_CHECK;
                else if ((idx_reg == '0 && in_byte != 8'h00) || idx_reg == LAST_FIELD)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:   phase_next = PH_HUNT;
            default:    phase_next = PH_HUNT;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        len_next   = len_reg;
        check_next = check_reg;
        store      = 1'b0;
        push       = 1'b0;
        unique case (phase_reg)
            PH_HUNT:    idx_next = '0;
            PH_LENGTH:  if (!too_long) len_next = in_byte[IDX_W-1:0];
            PH_COLLECT:
            begin
                check_next = fold_check(mode_reg, check_reg, in_byte);
                if (in_range)
                begin
                    store    = idx_reg < FIELD_END;
                    idx_next = idx_reg + 1'b1;
                end
            end
            PH_CHECK:
            begin
                push       = fire && (check_reg == in_byte);
                check_next = 8'h00;
            end
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            len_reg   <= '0;
            check_reg <= 8'h00;
            for (int i = 0; i < FIELD_COUNT; i++)
                held_reg[i] <= 8'h00;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            check_reg <= check_next;
            if (store)
                held_reg[idx_reg] <= in_byte;
        end
    end

    assign pkt.shape_type    = held_reg[0];
    assign pkt.center_x      = held_reg[1];
    assign pkt.center_y      = held_reg[2];
    assign pkt.circle_radius = held_reg[3];
    assign pkt.point_x       = held_reg[4];
    assign pkt.point_y       = held_reg[5];

    a_push_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fire && phase_reg == PH_CHECK))
        else $error("packet pushed outside check phase");

    a_check_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_CHECK) |=> (check_reg == 8'h00 && phase_reg == PH_HUNT))
        else $error("running check not cleared after check byte");

    a_hold_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(phase_reg) && $stable(check_reg) && $stable(idx_reg)))
        else $error("parser state moved without a byte");
endmodule

[src/lsp_queue.sv]
// Back end: short packet queue that holds results until the output side takes them.
// Depends on lsp_pkg.
module lsp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lsp_pkg::shape_pkt_t push_pkt,
    output logic                space,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lsp_pkg::shape_pkt_t pop_pkt
);
    import lsp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    shape_pkt_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign space     = count_reg != CNT_FULL;
    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_pkt   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_pkt;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (space || pop))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    a_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_pkt)))
        else $error("waiting packet changed");
endmodule

[src/lrc_framed_shape_packet_parser.sv]
// Top level of the LRC-framed shape packet parser: parser front end plus packet queue.
// Depends on lsp_pkg, lsp_if, lsp_parser and lsp_queue.
//
//   channel  | dir | payload                                           | handshake
//   rx       | in  | rx_byte                                           | valid/ready
//   pkt      | out | shape_type, center_x, center_y, circle_radius,   | valid/ready
//            |     | point_x, point_y                                  |
//   cfg      | in  | cfg_wr_en, cfg_index, cfg_wdata                   | write only
//
// One byte per cycle while rx.ready is high, parsed in the cycle it is accepted.
// A good packet is queued behind older ones as its check byte is accepted.
// rx.ready drops only when all QUEUE_DEPTH packet slots wait on pkt.
// Reset is asynchronous; it clears all state and held fields but not the queue slots.
module lrc_framed_shape_packet_parser #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lsp_byte_if.sink                        rx,
    lsp_pkt_if.source                       pkt,
    input  logic                            cfg_wr_en,
    input  logic [lsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lsp_pkg::*;

    cfg_wr_t    cfg;
    logic       fire;
    logic       push;
    logic       space;
    shape_pkt_t push_pkt;
    shape_pkt_t pop_pkt;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    assign rx.ready = space;
    assign fire     = rx.valid && space;

    lsp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (fire),
        .in_byte (rx.rx_byte),
        .push    (push),
        .pkt     (push_pkt)
    );

    lsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pkt  (push_pkt),
        .space     (space),
        .pop_valid (pkt.valid),
        .pop_ready (pkt.ready),
        .pop_pkt   (pop_pkt)
    );

    assign pkt.shape_type    = pop_pkt.shape_type;
    assign pkt.center_x      = pop_pkt.center_x;
    assign pkt.center_y      = pop_pkt.center_y;
    assign pkt.circle_radius = pop_pkt.circle_radius;
    assign pkt.point_x       = pop_pkt.point_x;
    assign pkt.point_y       = pop_pkt.point_y;
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lrc_framed_shape_packet_parser: byte-level parse predictor,
// directed frames, limit and check-mode sweeps, a long output stall, random traffic.
// Depends on lsp_pkg, lsp_if and the parser RTL.
module tb_top;
    import lsp_pkg::*;

    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_BYTES  = 110;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    lsp_byte_if rx_ch ();
    lsp_pkt_if  pkt_ch ();

    lrc_framed_shape_packet_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .pkt       (pkt_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // parser shadow state
    phase_t     cur_phase = PH_HUNT;
    logic [2:0] pay_idx   = '0;
    logic [2:0] decl_len  = '0;
    logic [7:0] run_chk   = '0;
    logic [7:0] held [FIELD_COUNT];
    logic [2:0] len_limit = 3'd6;
    logic       chk_mode  = CHECK_XOR;

    shape_pkt_t  expected_pkts [$];
    int unsigned field_errors = 0;
    int unsigned bytes_sent   = 0;
    bit          gap_on       = 1'b1;
    bit          stall_on     = 1'b1;
    bit          hold_req     = 1'b0;
    string       field_names [FIELD_COUNT];

    bit          hold_taken = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned burst_left = 0;
    bit          burst_rdy  = 1'b1;
    int unsigned cycles     = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        foreach (held[i])
        begin
            held[i] = 8'h00;
        end
        field_names[0] = "shape_type";
        field_names[1] = "center_x";
        field_names[2] = "center_y";
        field_names[3] = "circle_radius";
        field_names[4] = "point_x";
        field_names[5] = "point_y";
    end

    function automatic logic [7:0] lrc_fold(input logic [7:0] acc, input logic [7:0] b);
        return (chk_mode == CHECK_SUM) ? 8'(acc + b) : (acc ^ b);
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        shape_pkt_t p;
        case (cur_phase)
            PH_HUNT:
            begin
                pay_idx = '0;
                if (b == START_BYTE)
                begin
                    cur_phase = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (b > {5'b0, len_limit})
                begin
                    cur_phase = PH_HUNT;
                end
                else
                begin
                    cur_phase = PH_COLLECT;
                    decl_len  = b[2:0];
                end
            end
            PH_COLLECT:
            begin
                run_chk = lrc_fold(run_chk, b);
                if (pay_idx < decl_len)
                begin
                    if (pay_idx < FIELD_COUNT)
                    begin
                        held[pay_idx] = b;
                    end
                    if (pay_idx == 3'd0 && b != 8'h00)
                    begin
                        cur_phase = PH_CHECK;
                    end
                    if (pay_idx == FIELD_COUNT - 1)
                    begin
                        cur_phase = PH_CHECK;
                    end
                    pay_idx = pay_idx + 3'd1;
                end
                else
                begin
                    cur_phase = PH_CHECK;
                end
            end
            default:
            begin
                cur_phase = PH_HUNT;
                if (run_chk == b)
                begin
                    p = {held[0], held[1], held[2], held[3], held[4], held[5]};
                    expected_pkts.push_back(p);
                end
                run_chk = '0;
            end
        endcase
    endfunction

    function automatic logic [55:0] random_payload();
        logic [7:0] first;
        first = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        return {first, 48'({$urandom, $urandom})};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gap_on && $urandom_range(0, 4) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    // payload bytes go out only while the parser still collects
    task automatic send_frame(input logic [7:0] len_byte, input logic [55:0] payload,
                              input bit good);
        send_byte(START_BYTE);
        send_byte(len_byte);
        for (int i = 0; i < 7; i++)
        begin
            if (cur_phase == PH_COLLECT)
            begin
                send_byte(payload[55-8*i -: 8]);
            end
        end
        if (cur_phase == PH_CHECK)
        begin
            send_byte(good ? run_chk : ~run_chk);
        end
    endtask

    task automatic settle_idle();
        rx_ch.valid <= 1'b0;
        while (expected_pkts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_idx,
                             input logic [CFG_DATA_W-1:0] reg_val);
        settle_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= reg_idx;
        cfg_wdata <= reg_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (reg_idx == CFG_LENGTH_LIMIT)
        begin
            len_limit = reg_val;
        end
        else
        begin
            chk_mode = reg_val[0];
        end
    endtask

    task automatic sweep_lengths(input logic [2:0] lim);
        write_reg(CFG_LENGTH_LIMIT, lim);
        for (int n = 0; n <= 7; n++)
        begin
            send_frame(8'(n), random_payload(), 1'b1);
        end
    endtask

    task automatic send_random_frame();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        else
        begin
            send_byte(START_BYTE);
            if (kind < 16)
            begin
                send_byte(8'($urandom_range(int'(len_limit) + 1, 255)));
            end
            else
            begin
                send_byte(8'($urandom_range(0, int'(len_limit))));
                while (cur_phase == PH_COLLECT)
                begin
                    b = 8'($urandom);
                    if (pay_idx == 3'd0 && $urandom_range(0, 1) == 0)
                    begin
                        b = 8'h00;
                    end
                    // drop the rest of the frame
                    if (kind < 22 && $urandom_range(0, 2) == 0)
                    begin
                        break;
                    end
                    send_byte(b);
                end
                if (cur_phase == PH_CHECK)
                begin
                    send_byte((kind < 30) ? (run_chk ^ 8'($urandom_range(1, 255))) : run_chk);
                end
            end
        end
    endtask

    task automatic run_random_phase(input logic [2:0] lim, input logic mode);
        int unsigned start;
        write_reg(CFG_LENGTH_LIMIT, lim);
        write_reg(CFG_CHECK_MODE, {2'b00, mode});
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) send_random_frame();
    endtask

    task automatic test_directed_cases();
        send_frame(8'd6, 56'h00_11_22_33_44_FF_00, 1'b1);
        send_frame(8'd1, 56'h80_00_00_00_00_00_00, 1'b1);
        send_frame(8'd0, 56'h55_00_00_00_00_00_00, 1'b1);
        send_frame(8'd7, 56'h0, 1'b1);
        send_frame(8'hFF, 56'h0, 1'b1);
        send_frame(8'd2, 56'h00_AA_BB_00_00_00_00, 1'b1);
        send_frame(8'd1, 56'h7F_00_00_00_00_00_00, 1'b0);
    endtask

    task automatic test_length_limits();
        sweep_lengths(3'd0);
        sweep_lengths(3'd7);
        sweep_lengths(3'd3);
    endtask

    task automatic test_sum_check();
        write_reg(CFG_LENGTH_LIMIT, 3'd6);
        write_reg(CFG_CHECK_MODE, {2'b00, CHECK_SUM});
        send_frame(8'd6, 56'h00_FF_FF_FF_FF_FF_00, 1'b1);
        send_frame(8'd1, 56'hFF_00_00_00_00_00_00, 1'b1);
        send_frame(8'd0, 56'hC3_00_00_00_00_00_00, 1'b1);
        send_frame(8'd4, random_payload(), 1'b0);
        repeat (4) send_frame(8'($urandom_range(0, 6)), random_payload(), 1'b1);
    endtask

    task automatic test_backpressure();
        gap_on    = 1'b0;
        hold_req <= 1'b1;
        repeat (10) send_frame(8'($urandom_range(0, 6)), random_payload(), 1'b1);
        hold_req <= 1'b0;
        gap_on    = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(3'd6, CHECK_XOR);
        run_random_phase(3'd7, CHECK_SUM);
        run_random_phase(3'd0, CHECK_XOR);
        run_random_phase(3'd4, CHECK_SUM);
        settle_idle();
        gap_on    = 1'b0;
        stall_on <= 1'b0;
        run_random_phase(3'd6, CHECK_SUM);
    endtask

    initial
    begin
        pkt_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_req)
            begin
                hold_taken = 1'b0;
            end
            else if (!hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pkt_ch.ready <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 14);
                    burst_rdy  = !stall_on || ($urandom_range(0, 2) != 0);
                end
                burst_left--;
                pkt_ch.ready <= burst_rdy;
            end
        end
    end

    always @(posedge clk)
    begin : check_pkt
        shape_pkt_t got;
        shape_pkt_t want;
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
        begin
            got = {pkt_ch.shape_type, pkt_ch.center_x, pkt_ch.center_y,
                   pkt_ch.circle_radius, pkt_ch.point_x, pkt_ch.point_y};
            if (expected_pkts.size() == 0)
            begin
                $display("%0t: unexpected packet: expected none, actual %h", $time, got);
                field_errors++;
            end
            else
            begin
                want = expected_pkts.pop_front();
                for (int i = 0; i < FIELD_COUNT; i++)
                begin
                    if (got[47-8*i -: 8] !== want[47-8*i -: 8])
                    begin
                        $display("%0t: %s mismatch: expected %h, actual %h", $time,
                                 field_names[i], want[47-8*i -: 8], got[47-8*i -: 8]);
                        field_errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("lrc_framed_shape_packet_parser regression: fail");
        $finish;
    end

    initial
    begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_length_limits();
        test_sum_check();
        test_backpressure();
        test_random_traffic();
        settle_idle();
        repeat (10) @(posedge clk);
        if (field_errors == 0)
        begin
            $display("lrc_framed_shape_packet_parser regression: pass");
        end
        else
        begin
            $display("lrc_framed_shape_packet_parser regression: fail");
        end
        $finish;
    end

endmodule
